[hdl/tbar_pkg.sv]
// ----------------------------------------------------------------------------
// tbar_pkg
// Shared types and constants for the track buffer aging replacement block.
// ----------------------------------------------------------------------------
package tbar_pkg;

    localparam int SLOTS      = 10;
    localparam int AGE_FLOOR  = -1000;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int AGE_W      = $clog2(-AGE_FLOOR) + 1;
    localparam int TRACK_W    = 8;
    localparam int SLOT_OUT_W = 4;

    localparam logic signed [AGE_W-1:0] AGE_FLOOR_V = AGE_W'(AGE_FLOOR);

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic [TRACK_W-1:0]      track;
        logic signed [AGE_W-1:0] age;
    } t_slot_entry;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_slot_entry       wr_data;
        logic              clr;
    } t_mem_req;

endpackage

[hdl/tbar_slot_store.sv]
// ----------------------------------------------------------------------------
// tbar_slot_store
// Slot table memory with one read and one write port, registered read data,
// and per-entry live flags that make unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module tbar_slot_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tbar_pkg::t_mem_req    i_req,
    output tbar_pkg::t_slot_entry o_rd_data
);

    tbar_pkg::t_slot_entry r_mem [tbar_pkg::SLOTS];
    logic [tbar_pkg::SLOTS-1:0] r_live;
    tbar_pkg::t_slot_entry r_rd_data;
    logic r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_live <= r_live[i_req.rd_addr];
            end
            // clear wins: drop every entry back to its reset contents
            if (i_req.clr) begin
                r_live <= '0;
            end else if (i_req.wr_en) begin
                r_live[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_live ? r_rd_data : '0;

endmodule

[hdl/track_buffer_aging_replacement_core.sv]
// ----------------------------------------------------------------------------
// track_buffer_aging_replacement_core
// Aging replacement table for buffered disk tracks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request beat:
//   i_req_type selects an access (0) or a clear of all slots (1), i_track
//   names the track. Output channel (o_out_valid / i_out_ready) returns one
//   beat per request: o_hit = 1 when the track is already buffered, else 0
//   (fill needed, or clear done); o_slot is the slot holding or receiving it.
//   An access sweeps the slot memory through its single read port, one slot
//   a cycle: the accept step, a scan step for each slot, then an update
//   step that writes the hit or filled slot at age 0. A clear goes from
//   accept to the done state. One request is in work at a time; o_in_ready
//   is high again in the cycle after the result is loaded into the output
//   register, even if that result is still waiting to be taken.
//   A stalled receiver holds the result in the output register; a finished
//   request then waits in the done state until the output frees up.
//   Reset (synchronous, active low) clears all live flags of the table at
//   once, so every slot reads as invalid with age 0; no clearing pass runs.
// ----------------------------------------------------------------------------
module track_buffer_aging_replacement_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [tbar_pkg::TRACK_W-1:0]     i_track,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_hit,
    output logic [tbar_pkg::SLOT_OUT_W-1:0]  o_slot
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FILL, ST_DONE} t_state;

    t_state                             r_state;
    logic [tbar_pkg::SLOT_W-1:0]        r_idx;
    logic [tbar_pkg::TRACK_W-1:0]       r_trk;
    logic signed [tbar_pkg::AGE_W-1:0]  r_min_age;
    logic [tbar_pkg::SLOT_W-1:0]        r_victim;
    logic                               r_found;
    logic [tbar_pkg::SLOT_W-1:0]        r_found_idx;
    logic                               r_res_hit;
    logic [tbar_pkg::SLOT_W-1:0]        r_res_slot;
    logic                               r_out_valid;
    logic                               r_out_hit;
    logic [tbar_pkg::SLOT_OUT_W-1:0]    r_out_slot;

    tbar_pkg::t_mem_req                 mem_req;
    tbar_pkg::t_slot_entry              rd_ent;
    logic signed [tbar_pkg::AGE_W-1:0]  aged;
    logic                               in_beat;
    logic                               out_free;
    logic                               out_load;
    logic                               is_last;
    logic                               match;
    logic [tbar_pkg::SLOT_W-1:0]        sel_slot;

    tbar_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_ent)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign out_load    = out_free && ((r_state == ST_FILL) || (r_state == ST_DONE));
    assign is_last     = (r_idx == tbar_pkg::SLOT_W'(tbar_pkg::SLOTS - 1));
    assign match       = rd_ent.valid && (rd_ent.track == r_trk);
    assign sel_slot    = r_found ? r_found_idx : r_victim;

    // age one step unless the slot already sits at the floor
    assign aged = (rd_ent.age > tbar_pkg::AGE_FLOOR_V) ?
                  (rd_ent.age - tbar_pkg::AGE_W'(1)) : rd_ent.age;

    // memory sequencing: read slot i+1 while slot i is aged and written back
    always_comb begin
        mem_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    if (i_req_type == tbar_pkg::REQ_CLEAR) begin
                        mem_req.clr = 1'b1;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                    end
                end
            end
            ST_SCAN: begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = r_idx;
                mem_req.wr_data.valid = rd_ent.valid;
                mem_req.wr_data.track = rd_ent.track;
                mem_req.wr_data.age   = aged;
                if (!is_last) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_idx + tbar_pkg::SLOT_W'(1);
                end
            end
            ST_FILL: begin
                // hit and fill both leave the slot valid, on this track, age 0
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = sel_slot;
                mem_req.wr_data.valid = 1'b1;
                mem_req.wr_data.track = r_trk;
                mem_req.wr_data.age   = '0;
            end
            ST_DONE: begin
                mem_req = '0;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            // drop the beat once taken, unless a new one loads in this cycle
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_trk   <= i_track;
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        if (i_req_type == tbar_pkg::REQ_CLEAR) begin
                            r_res_hit  <= 1'b0;
                            r_res_slot <= '0;
                            r_state    <= ST_DONE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // first lowest age wins ties, last match wins hits
                    if ((r_idx == '0) || (aged < r_min_age)) begin
                        r_min_age <= aged;
                        r_victim  <= r_idx;
                    end
                    if (match) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_idx;
                    end
                    if (is_last) begin
                        r_state <= ST_FILL;
                    end else begin
                        r_idx <= r_idx + tbar_pkg::SLOT_W'(1);
                    end
                end
                ST_FILL: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_found;
                        r_out_slot  <= tbar_pkg::SLOT_OUT_W'(sel_slot);
                        r_state     <= ST_IDLE;
                    end else begin
                        r_res_hit  <= r_found;
                        r_res_slot <= sel_slot;
                        r_state    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_res_hit;
                        r_out_slot  <= tbar_pkg::SLOT_OUT_W'(r_res_slot);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_slot      = r_out_slot;

`ifndef SYNTH
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= tbar_pkg::SLOT_W'(tbar_pkg::SLOTS - 1)))
        else $error("scan index beyond slot table");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
        else $error("read and write hit the same slot in one cycle");

    a_access_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_req_type == tbar_pkg::REQ_ACCESS)) |=> (r_state == ST_SCAN))
        else $error("access beat did not start a scan");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |=> !(r_state == ST_SCAN))
        else $error("update step followed by a scan without a new beat");
`endif

endmodule
